### rtl/core/medd_pkg.sv
// Shared constants, widths and helper functions for the mono error-diffusion dither.
`timescale 1ns / 1ps

package medd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int FILL_W     = COL_W + 1;
    localparam int WIDTH_W    = 13;
    localparam int PIX_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int ERR_W      = 10;
    localparam int STORE_W    = 11;
    localparam int SUM_W      = 10;
    localparam int BIT_IDX_W  = 3;

    localparam logic [WIDTH_W-1:0]   LINE_WIDTH_RESET = WIDTH_W'(4096);
    localparam logic [BIT_IDX_W-1:0] BIT_LAST         = BIT_IDX_W'(7);
    localparam logic signed [SUM_W-1:0] SUM_THRESHOLD = SUM_W'(127);
    localparam logic signed [SUM_W-1:0] SUM_FULL      = SUM_W'(255);

    // Division by 3 as a multiply by 171/512; exact for magnitudes below 256
    localparam int DIV3_RECIP = 171;
    localparam int DIV3_SHIFT = 9;

    typedef logic [BYTE_W-1:0] t_byte;

    // Signed divide by three, truncating toward zero
    function automatic logic signed [ERR_W-1:0] div3_trunc(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0]   mag;
        logic [SUM_W+7:0]   prod;
        logic [SUM_W-1:0]   quo;
        mag  = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
        prod = (SUM_W+8)'(mag) * (SUM_W+8)'(DIV3_RECIP);
        quo  = SUM_W'(prod >> DIV3_SHIFT);
        return v[SUM_W-1] ? ERR_W'(-quo) : ERR_W'(quo);
    endfunction

endpackage

### rtl/core/medd_pix_if.sv
// Pixel input channel: valid/ready handshake carrying brightness and frame start.
`timescale 1ns / 1ps

interface medd_pix_if;
    import medd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] brightness;
    logic             start_of_frame;

    modport source (output valid, brightness, start_of_frame, input ready);
    modport sink   (input valid, brightness, start_of_frame, output ready);
endinterface

### rtl/core/medd_byte_if.sv
// Packed output channel: valid/ready handshake carrying one byte of 1-bit pixels.
`timescale 1ns / 1ps

interface medd_byte_if;
    import medd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte packed_byte;
    logic  row_end;

    modport source (output valid, packed_byte, row_end, input ready);
    modport sink   (input valid, packed_byte, row_end, output ready);
endinterface

### rtl/core/mono_error_diffusion_dither.sv
// Top level of the mono error-diffusion dither: 8-bit pixels in, packed 1-bit bytes out.
//
// Takes one pixel per clock cycle while the output takes its bytes, and emits one packed
// byte after every eighth pixel of a row and at row end. A pixel is accepted, its column's
// stored error is read from a 4096 x 11 RAM at the accepting edge, and in the compute
// stage the error update, threshold and bit packing are done and the byte, if any, is
// written to the output register when that stage fires. The read is issued when the
// pixel is accepted, ahead of the update, with a bypass for a write to the same column
// in that cycle (narrow rows). The output register lets a new pixel enter while a byte
// waits; only a byte that must be emitted while the previous one is still untaken
// stalls the input.
// Entries never written since reset read as zero through a fill count, so no clearing
// pass runs after reset. line_width is to be written by the user only while the block is
// idle; the block does not enforce this. 0 acts as 1 and values above 4096 act as 4096.
`timescale 1ns / 1ps

module mono_error_diffusion_dither (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [medd_pkg::WIDTH_W-1:0] i_cfg_wdata,
    medd_pix_if.sink                     i_pix,
    medd_byte_if.source                  o_byte
);
    import medd_pkg::*;

    // configuration
    logic [WIDTH_W-1:0] r_line_width;
    logic [WIDTH_W-1:0] w_eff;

    // front end (acceptance) state
    logic [COL_W-1:0]   r_col;
    logic               r_first_row;
    logic [FILL_W-1:0]  r_fill;

    // compute stage
    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_s1_bright;
    logic               r_s1_sof;
    logic [COL_W-1:0]   r_s1_col;
    logic               r_s1_first;
    logic               r_s1_last;
    logic               r_rd_valid;
    logic               r_fwd_hit;
    logic signed [STORE_W-1:0] r_fwd_data;

    logic signed [ERR_W-1:0] r_run_err;
    t_byte                   r_acc;

    // output register
    logic   r_out_valid;
    t_byte  r_out_byte;
    logic   r_out_row_end;

    logic               pix_acc;
    logic [COL_W-1:0]   col_eff;
    logic               fr_eff;
    logic               last_eff;
    logic [COL_W-1:0]   n_col;
    logic               n_first_row;

    logic signed [STORE_W-1:0] ram_rdata;
    logic signed [STORE_W-1:0] above_raw;
    logic signed [STORE_W-1:0] above;
    logic signed [ERR_W-1:0]   prev;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   adj;
    logic signed [ERR_W-1:0]   quo;
    logic signed [STORE_W-1:0] wr_data;
    logic                      dark;
    t_byte                     acc_base;
    t_byte                     acc_new;
    logic                      emit;
    logic                      out_free;
    logic                      s1_fire;

    // ------------------------------------------------------------------
    // effective width and acceptance
    // ------------------------------------------------------------------
    always_comb begin
        if (r_line_width == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (r_line_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = r_line_width;
        end
    end

    assign out_free      = !r_out_valid || o_byte.ready;
    assign emit          = (r_s1_col[BIT_IDX_W-1:0] == BIT_LAST) || r_s1_last;
    assign s1_fire       = r_s1_valid && (!emit || out_free);
    assign i_pix.ready   = !r_s1_valid || s1_fire;
    assign pix_acc       = i_pix.valid && i_pix.ready;

    // frame start restarts the column and the first-row masking
    assign col_eff  = i_pix.start_of_frame ? '0 : r_col;
    assign fr_eff   = i_pix.start_of_frame ? 1'b1 : r_first_row;
    assign last_eff = (WIDTH_W'(col_eff) + WIDTH_W'(1)) >= w_eff;

    assign n_col       = last_eff ? '0 : col_eff + COL_W'(1);
    assign n_first_row = last_eff ? 1'b0 : fr_eff;

    // ------------------------------------------------------------------
    // error store
    // ------------------------------------------------------------------
    medd_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_WIDTH)
    ) u_err_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (wr_data),
        .i_re    (pix_acc),
        .i_raddr (col_eff),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // per-pixel error update
    // ------------------------------------------------------------------
    always_comb begin
        if (r_fwd_hit) begin
            above_raw = r_fwd_data;
        end else if (r_rd_valid) begin
            above_raw = ram_rdata;
        end else begin
            above_raw = '0;
        end
        above    = r_s1_first ? '0 : above_raw;
        prev     = r_s1_sof ? '0 : r_run_err;
        sum      = SUM_W'(prev) + SUM_W'(signed'({1'b0, r_s1_bright})) + SUM_W'(above);
        dark     = !(sum > SUM_THRESHOLD);
        adj      = dark ? sum : sum - SUM_FULL;
        quo      = div3_trunc(adj);
        wr_data  = STORE_W'(quo) + STORE_W'(prev);
        acc_base = r_s1_sof ? '0 : r_acc;
        acc_new  = acc_base | (dark ? (t_byte'(8'h80) >> r_s1_col[BIT_IDX_W-1:0]) : '0);
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_col        <= '0;
            r_first_row  <= 1'b1;
            r_fill       <= '0;
            r_s1_valid   <= 1'b0;
            r_run_err    <= '0;
            r_acc        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_line_width <= i_cfg_wdata;
            end

            if (pix_acc) begin
                r_col       <= n_col;
                r_first_row <= n_first_row;
            end

            // columns are written in order from zero, so the written entries form a prefix
            if (s1_fire && (FILL_W'(r_s1_col) >= r_fill)) begin
                r_fill <= FILL_W'(r_s1_col) + FILL_W'(1);
            end

            if (pix_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_run_err <= r_s1_last ? '0 : quo;
                r_acc     <= emit ? '0 : acc_new;
            end

            if (s1_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_bright <= i_pix.brightness;
            r_s1_sof    <= i_pix.start_of_frame;
            r_s1_col    <= col_eff;
            r_s1_first  <= fr_eff;
            r_s1_last   <= last_eff;
            r_rd_valid  <= FILL_W'(col_eff) < r_fill;
            // bypass a write to the same column landing in this cycle
            r_fwd_hit   <= s1_fire && (r_s1_col == col_eff);
            r_fwd_data  <= wr_data;
        end
        if (s1_fire && emit) begin
            r_out_byte    <= acc_new;
            r_out_row_end <= r_s1_last;
        end
    end

    assign o_byte.valid       = r_out_valid;
    assign o_byte.packed_byte = r_out_byte;
    assign o_byte.row_end     = r_out_row_end;

endmodule

### rtl/core/medd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module medd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data between reads; same-address write returns old data
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
